// File: rtl/multi_channel_sample_ring_max_macros.svh
// Assertion macros for the sample ring block.
// Included by files that carry concurrent checks; no dependencies.
`ifndef MULTI_CHANNEL_SAMPLE_RING_MAX_MACROS_SVH
`define MULTI_CHANNEL_SAMPLE_RING_MAX_MACROS_SVH

`ifndef SYNTHESIS
`define MCSRM_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mcsrm check failed");
`define MCSRM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mcsrm check failed");
`else
`define MCSRM_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define MCSRM_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// File: rtl/mcsrm_pkg.sv
// Shared constants, types and state codes for the sample ring block.
// No dependencies.
package mcsrm_pkg;

  localparam int METRICS    = 8;
  localparam int RING_DEPTH = 256;

  localparam int IDX_W    = 8;
  localparam int SAMPLE_W = 32;
  localparam int REPORT_W = 6;
  localparam int COUNT_W  = 32;

  localparam int MIDX_W    = (METRICS > 1) ? $clog2(METRICS) : 1;
  localparam int SLOT_W    = $clog2(RING_DEPTH);
  localparam int ADDR_W    = MIDX_W + SLOT_W;
  localparam int MEM_WORDS = 2 ** ADDR_W;

  localparam logic MODE_RECORD   = 1'b0;
  localparam logic MODE_SNAPSHOT = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LAST,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                we;
    logic [ADDR_W-1:0]   addr;
    logic [SAMPLE_W-1:0] data;
  } ram_wr_t;

endpackage

// File: rtl/mcsrm_if.sv
// Valid/ready channel interfaces for sample items and report items.
// Depends on mcsrm_pkg.
interface mcsrm_in_if import mcsrm_pkg::*; ;
  logic                valid;
  logic                ready;
  logic                mode;
  logic [IDX_W-1:0]    metric_index;
  logic [SAMPLE_W-1:0] sample_value;

  modport source (output valid, mode, metric_index, sample_value, input ready);
  modport sink (input valid, mode, metric_index, sample_value, output ready);
endinterface

interface mcsrm_out_if import mcsrm_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [REPORT_W-1:0] report_metric;
  logic                has_data;
  logic [SAMPLE_W-1:0] latest_value;
  logic [SAMPLE_W-1:0] max_value;
  logic                last_of_run;

  modport source (output valid, report_metric, has_data, latest_value, max_value,
                  last_of_run, input ready);
  modport sink (input valid, report_metric, has_data, latest_value, max_value,
                last_of_run, output ready);
endinterface

// File: rtl/mcsrm_ram.sv
// Sample store: one write port, one read port with registered read data.
// Depends on mcsrm_pkg.
module mcsrm_ram import mcsrm_pkg::*; (
  input  logic                clk,
  input  ram_wr_t             wr,
  input  logic [ADDR_W-1:0]   raddr,
  output logic [SAMPLE_W-1:0] rdata
);

  logic [SAMPLE_W-1:0] mem [MEM_WORDS];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/multi_channel_sample_ring_max.sv
// Record items: one per cycle while idle, written to the store in the cycle they
// are taken. Snapshot items: per metric a latest read, a full ring scan, a drain
// and an emit, paced by the store's single read port, plus any output stall.
// Reset: a clearing pass writes zero to all MEM_WORDS store words, with ready
// low; counts and slot pointers clear at once.
module multi_channel_sample_ring_max import mcsrm_pkg::*; (
  input logic         clk,
  input logic         rst,
  mcsrm_in_if.sink    in_ch,
  mcsrm_out_if.source out_ch
);

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_DEPTH - 1);
  localparam logic [MIDX_W-1:0] M_LAST    = MIDX_W'(METRICS - 1);

  state_t state, state_next;

  logic [ADDR_W-1:0]   clr_addr;
  logic [COUNT_W-1:0]  write_count [METRICS];
  logic [SLOT_W-1:0]   wr_slot [METRICS];
  logic [SLOT_W-1:0]   last_slot [METRICS];
  logic [MIDX_W-1:0]   cur_m;
  logic [SLOT_W-1:0]   scan_slot;
  logic [SAMPLE_W-1:0] latest;
  logic [SAMPLE_W-1:0] max_acc;
  logic [SAMPLE_W-1:0] rdata;
  logic [ADDR_W-1:0]   raddr;
  ram_wr_t             wr;

  logic                in_fire;
  logic                rec_ok;
  logic [MIDX_W-1:0]   rec_m;
  logic [COUNT_W-1:0]  rec_cnt;
  logic                clearing;
  logic                emit_go;
  logic                rd_gt;
  logic                cur_has;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign rec_m   = in_ch.metric_index[MIDX_W-1:0];
  assign rec_ok  = in_fire && (in_ch.mode == MODE_RECORD) &&
                   (in_ch.metric_index < IDX_W'(METRICS));
  assign rec_cnt = write_count[rec_m];
  assign rd_gt   = rdata > max_acc;
  assign cur_has = write_count[cur_m] != '0;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == '1) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire && in_ch.mode == MODE_SNAPSHOT) state_next = ST_LAST;
      end
      ST_LAST:  state_next = ST_SCAN;
      ST_SCAN: begin
        if (scan_slot == SLOT_LAST) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_EMIT;
      ST_EMIT: begin
        if (emit_go) state_next = (cur_m == M_LAST) ? ST_IDLE : ST_LAST;
      end
      default:  state_next = ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    clearing    = 1'b0;
    emit_go     = 1'b0;
    in_ch.ready = 1'b0;
    raddr       = {cur_m, scan_slot};
    case (state)
      ST_CLEAR: clearing = 1'b1;
      ST_IDLE:  in_ch.ready = 1'b1;
      ST_LAST:  raddr = {cur_m, last_slot[cur_m]};
      ST_EMIT:  emit_go = !out_ch.valid || out_ch.ready;
      default: ;
    endcase
  end

  always_comb begin
    wr.we   = clearing || rec_ok;
    wr.addr = clearing ? clr_addr : {rec_m, wr_slot[rec_m]};
    wr.data = clearing ? '0 : in_ch.sample_value;
  end

  mcsrm_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < METRICS; i++) begin
        write_count[i] <= '0;
        wr_slot[i]     <= '0;
        last_slot[i]   <= '0;
      end
    end else if (rec_ok) begin
      write_count[rec_m] <= rec_cnt + 1'b1;
      last_slot[rec_m]   <= wr_slot[rec_m];
      // count wrap restarts the slot at zero
      if (rec_cnt == '1 || wr_slot[rec_m] == SLOT_LAST) begin
        wr_slot[rec_m] <= '0;
      end else begin
        wr_slot[rec_m] <= wr_slot[rec_m] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_m <= '0;
    end else if (state == ST_IDLE) begin
      cur_m <= '0;
    end else if (state == ST_EMIT && emit_go && cur_m != M_LAST) begin
      cur_m <= cur_m + 1'b1;
    end
  end

  // scan datapath: read data is registered and follows its issued address in the next cycle
  always_ff @(posedge clk) begin
    case (state)
      ST_LAST: begin
        scan_slot <= '0;
        max_acc   <= '0;
      end
      ST_SCAN: begin
        scan_slot <= scan_slot + 1'b1;
        if (scan_slot == '0) begin
          latest <= rdata;
        end else if (rd_gt) begin
          max_acc <= rdata;
        end
      end
      ST_DRAIN: begin
        if (rd_gt) max_acc <= rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (state == ST_EMIT && emit_go) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && emit_go) begin
      out_ch.report_metric <= REPORT_W'(cur_m);
      out_ch.has_data      <= cur_has;
      out_ch.latest_value  <= cur_has ? latest : '0;
      out_ch.max_value     <= cur_has ? max_acc : '0;
      out_ch.last_of_run   <= cur_m == M_LAST;
    end
  end

`include "multi_channel_sample_ring_max_macros.svh"

  `MCSRM_ASSERT_NEXT(a_count_step, clk, rst, rec_ok, write_count[$past(rec_m)] == $past(rec_cnt) + 32'd1)
  `MCSRM_ASSERT_SAME(a_last_metric, clk, rst, out_ch.valid && out_ch.last_of_run, out_ch.report_metric == REPORT_W'(METRICS - 1))
  `MCSRM_ASSERT_SAME(a_no_write_in_scan, clk, rst, state == ST_LAST || state == ST_SCAN || state == ST_DRAIN, !wr.we)
  `MCSRM_ASSERT_NEXT(a_snap_start, clk, rst, in_fire && in_ch.mode == MODE_SNAPSHOT, state == ST_LAST && cur_m == '0)

endmodule

// File: verif/multi_channel_sample_ring_max_checker.sv
// Checker for the sample ring block: keeps a shadow copy of every metric ring and its
// write count, predicts the snapshot reports and compares them with the output items.
// Depends on mcsrm_pkg and the channel interfaces in mcsrm_if.sv.
`timescale 1ns / 1ps

module multi_channel_sample_ring_max_checker import mcsrm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  mcsrm_in_if         in_mon,
  mcsrm_out_if        out_mon,
  output int unsigned failures,
  output int unsigned outstanding
);

  typedef struct {
    logic [REPORT_W-1:0] metric;
    logic                has_data;
    logic [SAMPLE_W-1:0] latest;
    logic [SAMPLE_W-1:0] peak;
    logic                last;
  } metric_report_t;

  logic [SAMPLE_W-1:0] ring_shadow [METRICS][RING_DEPTH];
  logic [COUNT_W-1:0]  count_shadow [METRICS];
  metric_report_t      pending_reports [$];
  int unsigned         fail_count = 0;

  always @(posedge clk) begin
    metric_report_t     want;
    logic [COUNT_W-1:0] cnt;
    if (rst) begin
      for (int m = 0; m < METRICS; m++) begin
        count_shadow[m] = '0;
        for (int s = 0; s < RING_DEPTH; s++) ring_shadow[m][s] = '0;
      end
      pending_reports.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (pending_reports.size() == 0) begin
          $error("unexpected report item for metric %0d", out_mon.report_metric);
          fail_count++;
        end else begin
          want = pending_reports.pop_front();
          if (out_mon.report_metric !== want.metric) begin
            $error("report_metric: expected %0d, got %0d", want.metric, out_mon.report_metric);
            fail_count++;
          end
          if (out_mon.has_data !== want.has_data) begin
            $error("has_data: expected %0d, got %0d", want.has_data, out_mon.has_data);
            fail_count++;
          end
          if (out_mon.latest_value !== want.latest) begin
            $error("latest_value: expected 0x%08h, got 0x%08h", want.latest,
                   out_mon.latest_value);
            fail_count++;
          end
          if (out_mon.max_value !== want.peak) begin
            $error("max_value: expected 0x%08h, got 0x%08h", want.peak, out_mon.max_value);
            fail_count++;
          end
          if (out_mon.last_of_run !== want.last) begin
            $error("last_of_run: expected %0d, got %0d", want.last, out_mon.last_of_run);
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.mode == MODE_RECORD) begin
          if (in_mon.metric_index < METRICS) begin
            cnt = count_shadow[in_mon.metric_index];
            ring_shadow[in_mon.metric_index][cnt % RING_DEPTH] = in_mon.sample_value;
            count_shadow[in_mon.metric_index] = cnt + 1'b1;
          end
        end else begin
          for (int m = 0; m < METRICS; m++) begin
            cnt           = count_shadow[m];
            want.metric   = REPORT_W'(m);
            want.has_data = (cnt != 0);
            want.latest   = '0;
            want.peak     = '0;
            if (cnt != 0) begin
              want.latest = ring_shadow[m][(cnt - 1'b1) % RING_DEPTH];
              for (int s = 0; s < RING_DEPTH; s++) begin
                if (ring_shadow[m][s] > want.peak) want.peak = ring_shadow[m][s];
              end
            end
            want.last = (m == METRICS - 1);
            pending_reports.push_back(want);
          end
        end
      end
    end
    failures    <= fail_count;
    outstanding <= pending_reports.size();
  end

endmodule

// File: verif/multi_channel_sample_ring_max_tb.sv
// Testbench top for the sample ring block: clock, reset, record and snapshot stimulus,
// receiver back-pressure and the verdict. Depends on mcsrm_pkg, mcsrm_if.sv, the block
// and multi_channel_sample_ring_max_checker.
`timescale 1ns / 1ps

module multi_channel_sample_ring_max_tb;
  import mcsrm_pkg::*;

  localparam int LIMIT            = 4_000_000;
  localparam int HOLD_CYCLES      = 3000;
  localparam int TAIL_CYCLES      = 300;
  localparam int RANDOM_PER_PHASE = 71;

  logic        clk;
  logic        rst;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  bit          hold_req;
  bit          hold_done;
  int unsigned cycle_count;
  int unsigned failures;
  int unsigned outstanding;

  mcsrm_in_if  in_ch ();
  mcsrm_out_if out_ch ();

  multi_channel_sample_ring_max u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  multi_channel_sample_ring_max_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .failures    (failures),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: pick_sample = '0;
      1: pick_sample = '1;
      default: pick_sample = $urandom;
    endcase
  endfunction

  task automatic offer_item(input logic mode, input logic [IDX_W-1:0] idx,
                            input logic [SAMPLE_W-1:0] val);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= mode;
    in_ch.metric_index <= idx;
    in_ch.sample_value <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic offer_random_item();
    logic             mode;
    logic [IDX_W-1:0] idx;
    mode = ($urandom_range(0, 15) == 0) ? MODE_SNAPSHOT : MODE_RECORD;
    if ($urandom_range(0, 99) < 85) idx = IDX_W'($urandom_range(0, METRICS - 1));
    else idx = IDX_W'($urandom_range(0, 255));
    offer_item(mode, idx, pick_sample());
  endtask

  // receiver: random ready, or one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    hold_done    = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.mode         = MODE_RECORD;
    in_ch.metric_index = '0;
    in_ch.sample_value = '0;
    tx_idle_pct        = 34;
    rx_idle_pct        = 75;
    hold_req           = 1'b0;
    rst                = 1'b1;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // directed
    offer_item(MODE_SNAPSHOT, 8'd0, 32'h0);
    offer_item(MODE_RECORD, 8'd0, 32'hFFFF_FFFF);
    offer_item(MODE_RECORD, 8'd7, 32'h0000_0000);
    offer_item(MODE_RECORD, 8'd8, 32'hDEAD_BEEF);
    offer_item(MODE_RECORD, 8'd255, 32'hFFFF_FFFF);
    offer_item(MODE_RECORD, 8'd1, 32'h0000_0001);
    offer_item(MODE_RECORD, 8'd1, 32'h8000_0000);
    offer_item(MODE_RECORD, 8'd1, 32'h0000_0002);
    offer_item(MODE_RECORD, 8'd2, 32'h7FFF_FFFF);
    offer_item(MODE_RECORD, 8'd3, 32'h0000_0000);
    offer_item(MODE_RECORD, 8'd6, 32'h5555_5555);
    offer_item(MODE_RECORD, 8'd6, 32'hAAAA_AAAA);
    offer_item(MODE_SNAPSHOT, 8'd255, 32'hFFFF_FFFF);
    offer_item(MODE_RECORD, 8'd128, 32'h1234_5678);
    offer_item(MODE_SNAPSHOT, 8'd170, 32'hAAAA_AAAA);

    // long receiver hold-off while items keep coming
    hold_req = 1'b1;
    offer_item(MODE_SNAPSHOT, 8'd0, 32'h0);
    repeat (20) offer_random_item();
    offer_item(MODE_SNAPSHOT, 8'd85, 32'h5555_5555);

    repeat (RANDOM_PER_PHASE) offer_random_item();

    tx_idle_pct = 75;
    rx_idle_pct = 34;
    repeat (RANDOM_PER_PHASE) offer_random_item();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (RANDOM_PER_PHASE) offer_random_item();
    offer_item(MODE_SNAPSHOT, 8'd0, 32'h0);

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
